// ----- src/tksi_pkg.sv -----
package tksi_pkg;

    // request modes
    localparam logic [1:0] MODE_INS  = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_CLR  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_ZERO  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    localparam int KEY_W      = 32;
    localparam int POS_W      = 6;
    localparam int READ_LIMIT = 64;

    // per-cycle command to the cell chain
    typedef struct packed {
        logic ins;   // place the new entry, shift the tail down by one
        logic rot;   // rotate the occupied part one place toward cell 0
    } t_chain_ctl;

endpackage

// ----- src/tksi_cell.sv -----
module tksi_cell #(
    parameter int TAG_BITS = 10
) (
    input  logic                        i_clk,
    input  tksi_pkg::t_chain_ctl        i_ctl,
    input  logic                        i_occupied,
    input  logic                        i_is_tail,
    input  logic [tksi_pkg::KEY_W-1:0]  i_new_price,
    input  logic [tksi_pkg::KEY_W-1:0]  i_new_amount,
    input  logic [TAG_BITS-1:0]         i_new_tag,
    input  logic                        i_left_ge,
    input  logic [tksi_pkg::KEY_W-1:0]  i_left_price,
    input  logic [tksi_pkg::KEY_W-1:0]  i_left_amount,
    input  logic [TAG_BITS-1:0]         i_left_tag,
    input  logic [tksi_pkg::KEY_W-1:0]  i_right_price,
    input  logic [tksi_pkg::KEY_W-1:0]  i_right_amount,
    input  logic [TAG_BITS-1:0]         i_right_tag,
    input  logic [tksi_pkg::KEY_W-1:0]  i_head_price,
    input  logic [tksi_pkg::KEY_W-1:0]  i_head_amount,
    input  logic [TAG_BITS-1:0]         i_head_tag,
    output logic                        o_ge,
    output logic                        o_ins_here,
    output logic [tksi_pkg::KEY_W-1:0]  o_price,
    output logic [tksi_pkg::KEY_W-1:0]  o_amount,
    output logic [TAG_BITS-1:0]         o_tag
);
    import tksi_pkg::*;

    logic [KEY_W-1:0]    r_price, n_price;
    logic [KEY_W-1:0]    r_amount, n_amount;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                less;

    // stored key below the new key: the new entry goes in front of it
    assign less = (r_price < i_new_price) ||
                  ((r_price == i_new_price) && (r_amount < i_new_amount));
    assign o_ge       = i_occupied && !less;
    assign o_ins_here = !o_ge && i_left_ge;

    always_comb begin
        n_price  = r_price;
        n_amount = r_amount;
        n_tag    = r_tag;
        if (i_ctl.ins && !o_ge) begin
            if (i_left_ge) begin
                n_price  = i_new_price;
                n_amount = i_new_amount;
                n_tag    = i_new_tag;
            end else begin
                n_price  = i_left_price;
                n_amount = i_left_amount;
                n_tag    = i_left_tag;
            end
        end else if (i_ctl.rot) begin
            if (i_is_tail) begin
                n_price  = i_head_price;
                n_amount = i_head_amount;
                n_tag    = i_head_tag;
            end else begin
                n_price  = i_right_price;
                n_amount = i_right_amount;
                n_tag    = i_right_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_price  <= n_price;
        r_amount <= n_amount;
        r_tag    <= n_tag;
    end

    assign o_price  = r_price;
    assign o_amount = r_amount;
    assign o_tag    = r_tag;

endmodule

// ----- src/tksi_chain.sv -----
module tksi_chain #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 10,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int IW       = $clog2(CAPACITY)
) (
    input  logic                        i_clk,
    input  tksi_pkg::t_chain_ctl        i_ctl,
    input  logic [CW-1:0]               i_count,
    input  logic [tksi_pkg::KEY_W-1:0]  i_price,
    input  logic [tksi_pkg::KEY_W-1:0]  i_amount,
    input  logic [TAG_BITS-1:0]         i_tag,
    output logic [tksi_pkg::KEY_W-1:0]  o_head_price,
    output logic [tksi_pkg::KEY_W-1:0]  o_head_amount,
    output logic [TAG_BITS-1:0]         o_head_tag,
    output logic [IW-1:0]               o_ins_pos
);
    import tksi_pkg::*;

    logic [KEY_W-1:0]    c_price  [CAPACITY];
    logic [KEY_W-1:0]    c_amount [CAPACITY];
    logic [TAG_BITS-1:0] c_tag    [CAPACITY];
    logic [CAPACITY-1:0] c_ge;
    logic [CAPACITY-1:0] c_ins;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                left_ge;
        logic [KEY_W-1:0]    left_price, left_amount, right_price, right_amount;
        logic [TAG_BITS-1:0] left_tag, right_tag;

        if (g == 0) begin : g_first
            assign left_ge     = 1'b1;
            assign left_price  = '0;
            assign left_amount = '0;
            assign left_tag    = '0;
        end else begin : g_mid
            assign left_ge     = c_ge[g-1];
            assign left_price  = c_price[g-1];
            assign left_amount = c_amount[g-1];
            assign left_tag    = c_tag[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign right_price  = '0;
            assign right_amount = '0;
            assign right_tag    = '0;
        end else begin : g_inner
            assign right_price  = c_price[g+1];
            assign right_amount = c_amount[g+1];
            assign right_tag    = c_tag[g+1];
        end

        tksi_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (i_ctl),
            .i_occupied     (CW'(g) < i_count),
            .i_is_tail      (CW'(g + 1) == i_count),
            .i_new_price    (i_price),
            .i_new_amount   (i_amount),
            .i_new_tag      (i_tag),
            .i_left_ge      (left_ge),
            .i_left_price   (left_price),
            .i_left_amount  (left_amount),
            .i_left_tag     (left_tag),
            .i_right_price  (right_price),
            .i_right_amount (right_amount),
            .i_right_tag    (right_tag),
            .i_head_price   (c_price[0]),
            .i_head_amount  (c_amount[0]),
            .i_head_tag     (c_tag[0]),
            .o_ge           (c_ge[g]),
            .o_ins_here     (c_ins[g]),
            .o_price        (c_price[g]),
            .o_amount       (c_amount[g]),
            .o_tag          (c_tag[g])
        );
    end

    // one-hot insertion point to index
    always_comb begin
        o_ins_pos = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (c_ins[k]) begin
                o_ins_pos = o_ins_pos | IW'(k);
            end
        end
    end

    assign o_head_price  = c_price[0];
    assign o_head_amount = c_amount[0];
    assign o_head_tag    = c_tag[0];

endmodule

// ----- src/two_key_sorted_insert_table.sv -----
// Sorted two-key table: entries are kept by price descending, then amount
// descending, ties in arrival order, each entry carrying a tag.
// Input channel (i_valid / o_ready) carries one request: mode, price,
// amount, tag. Output channel (o_valid / i_ready) carries results: status,
// position, entry fields and a last flag on the final result of a request.
// Insert, clear, empty read and full or zero-key rejects give one result,
// registered in the cycle after the request is taken. Inserts run at one per
// cycle while the output is not stalled: every cell compares its key with
// the new one and shifts at once. A read of N entries rotates the cell chain
// one place per cycle, stalling while an emitted result waits, and further
// requests are held off until it is done; the head cell feeds the output,
// and the first 64 entries are emitted. After N rotations the chain is back in order.
// The single output register is refilled in the cycle it is taken, so a
// stalled receiver holds the result and back-pressures both the input and
// an ongoing read; nothing is dropped.
// Reset empties the table and the output; entry contents need no reset.
module two_key_sorted_insert_table #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_mode,
    input  logic [tksi_pkg::KEY_W-1:0]  i_price,
    input  logic [tksi_pkg::KEY_W-1:0]  i_amount,
    input  logic [TAG_BITS-1:0]         i_tag,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [tksi_pkg::POS_W-1:0]  o_position,
    output logic [tksi_pkg::KEY_W-1:0]  o_out_price,
    output logic [tksi_pkg::KEY_W-1:0]  o_out_amount,
    output logic [TAG_BITS-1:0]         o_out_tag,
    output logic                        o_last
);
    import tksi_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;

    logic                r_valid, n_valid;
    logic [1:0]          r_status, n_status;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [KEY_W-1:0]    r_price, n_price;
    logic [KEY_W-1:0]    r_amount, n_amount;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                r_last, n_last;

    t_chain_ctl          ctl;
    logic [KEY_W-1:0]    head_price, head_amount;
    logic [TAG_BITS-1:0] head_tag;
    logic [IW-1:0]       ins_pos;

    logic out_free, take, key_ok, full, emit, read_step, idx_last;

    assign out_free = !r_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_free;
    assign take     = i_valid && o_ready;
    assign key_ok   = (i_price != '0) && (i_amount != '0);
    assign full     = (r_count == CW'(CAPACITY));

    // read progress: entries past the emit limit still rotate, silently
    assign emit      = (32'(r_idx) < READ_LIMIT);
    assign read_step = (r_state == ST_READ) && (!emit || out_free);
    assign idx_last  = ((r_idx + CW'(1)) == r_count) || (32'(r_idx) == READ_LIMIT - 1);

    tksi_chain #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS),
        .CW       (CW),
        .IW       (IW)
    ) u_chain (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_count       (r_count),
        .i_price       (i_price),
        .i_amount      (i_amount),
        .i_tag         (i_tag),
        .o_head_price  (head_price),
        .o_head_amount (head_amount),
        .o_head_tag    (head_tag),
        .o_ins_pos     (ins_pos)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        ctl      = '0;
        n_valid  = r_valid && !i_ready;
        n_status = r_status;
        n_pos    = r_pos;
        n_price  = r_price;
        n_amount = r_amount;
        n_tag    = r_tag;
        n_last   = r_last;

        if (take) begin
            case (i_mode)
                MODE_INS: begin
                    n_valid  = 1'b1;
                    n_pos    = '0;
                    n_price  = '0;
                    n_amount = '0;
                    n_tag    = '0;
                    n_last   = 1'b1;
                    if (!key_ok) begin
                        n_status = STAT_ZERO;
                    end else if (full) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_status = STAT_OK;
                        n_pos    = POS_W'(ins_pos);
                        ctl.ins  = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
                MODE_READ: begin
                    if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = STAT_EMPTY;
                        n_pos    = '0;
                        n_price  = '0;
                        n_amount = '0;
                        n_tag    = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_state = ST_READ;
                        n_idx   = '0;
                    end
                end
                MODE_CLR: begin
                    n_count  = '0;
                    n_valid  = 1'b1;
                    n_status = STAT_OK;
                    n_pos    = '0;
                    n_price  = '0;
                    n_amount = '0;
                    n_tag    = '0;
                    n_last   = 1'b1;
                end
                default: begin
                    // drop unused mode: no result, no state change
                end
            endcase
        end

        if (read_step) begin
            ctl.rot = 1'b1;
            n_idx   = r_idx + CW'(1);
            if (emit) begin
                n_valid  = 1'b1;
                n_status = STAT_OK;
                n_pos    = POS_W'(r_idx);
                n_price  = head_price;
                n_amount = head_amount;
                n_tag    = head_tag;
                n_last   = idx_last;
            end
            if ((r_idx + CW'(1)) == r_count) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // hold result payload until taken
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pos    <= n_pos;
        r_price  <= n_price;
        r_amount <= n_amount;
        r_tag    <= n_tag;
        r_last   <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_position   = r_pos;
    assign o_out_price  = r_price;
    assign o_out_amount = r_amount;
    assign o_out_tag    = r_tag;
    assign o_last       = r_last;

endmodule
